@@ rtl/core/salu_pkg.sv @@
// ----------------------------------------------------------------------------
// salu_pkg - shared types and constants for the signed ALU
// Command codes, sequencer states, payload words and control struct.
// ----------------------------------------------------------------------------
`default_nettype none

package salu_pkg;

	localparam logic [2:0] CMD_ADD    = 3'd0;
	localparam logic [2:0] CMD_SUB    = 3'd1;
	localparam logic [2:0] CMD_MUL    = 3'd2;
	localparam logic [2:0] CMD_DIV    = 3'd3;
	localparam logic [2:0] CMD_STORE  = 3'd4;
	localparam logic [2:0] CMD_RECALL = 3'd5;

	localparam logic [31:0] DIV0_POS  = 32'h7FFF_FFFF;
	localparam logic [31:0] DIV0_NEG  = 32'h8000_0000;
	localparam logic [31:0] DIV0_ZERO = 32'h0000_0000;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ARITH,
		ST_ABS_A,
		ST_ABS_B,
		ST_ITER,
		ST_FIX,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic        [2:0]  command;
		logic signed [31:0] operand_a;
		logic signed [31:0] operand_b;
	} req_word_t;

	typedef struct packed {
		logic signed [31:0] value;
		logic               status;
	} rsp_word_t;

	typedef struct packed {
		state_t phase;
		logic   load;
	} ctl_t;

endpackage

`default_nettype wire

@@ rtl/core/salu_addsub.sv @@
// ----------------------------------------------------------------------------
// salu_addsub - shared 33-bit adder/subtractor
// x + y or x - y with carry out; the one arithmetic unit of the block.
// ----------------------------------------------------------------------------
`default_nettype none

module salu_addsub (
	input  wire logic [32:0] x,
	input  wire logic [32:0] y,
	input  wire logic        sub,
	output logic      [33:0] sum
);

	// carry out in sum[33]; for subtract it is set when x >= y
	assign sum = {1'b0, x} + {1'b0, y ^ {33{sub}}} + {33'd0, sub};

endmodule

`default_nettype wire

@@ rtl/core/salu_seq.sv @@
// ----------------------------------------------------------------------------
// salu_seq - command sequencer
// Steps mul/div words through sign fixup, 32 shift iterations, result fixup.
// ----------------------------------------------------------------------------
`default_nettype none

module salu_seq (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               req_valid,
	input  wire salu_pkg::req_word_t req,
	output logic                    req_stall,
	output logic                    rsp_valid,
	input  wire logic               rsp_stall,
	output salu_pkg::ctl_t          ctl
);
	import salu_pkg::*;

	state_t     state_q, state_d;
	logic [4:0] cnt_q;
	logic       accept;
	logic       last;

	assign accept = req_valid && (state_q == ST_IDLE);
	assign last   = (cnt_q == 5'h1F);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (req.command)
						CMD_ADD, CMD_SUB: state_d = ST_ARITH;
						CMD_MUL:          state_d = ST_ABS_A;
						CMD_DIV:          state_d = (req.operand_b == '0) ? ST_OUT : ST_ABS_A;
						default:          state_d = ST_OUT;
					endcase
				end
			end
			ST_ARITH: state_d = ST_OUT;
			ST_ABS_A: state_d = ST_ABS_B;
			ST_ABS_B: state_d = ST_ITER;
			ST_ITER:  state_d = last ? ST_FIX : ST_ITER;
			ST_FIX:   state_d = ST_OUT;
			ST_OUT:   state_d = rsp_stall ? ST_OUT : ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		req_stall = (state_q != ST_IDLE);
		rsp_valid = (state_q == ST_OUT);
		ctl.phase = state_q;
		ctl.load  = accept;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_ABS_B)
				cnt_q <= '0;
			else if (state_q == ST_ITER)
				cnt_q <= cnt_q + 5'd1;
		end
	end

endmodule

`default_nettype wire

@@ rtl/core/salu_datapath.sv @@
// ----------------------------------------------------------------------------
// salu_datapath - operand, partial result and memory registers
// Routes the shared adder for each phase; shift-add multiply and
// restoring divide on operand magnitudes, signs fixed at the end.
// ----------------------------------------------------------------------------
`default_nettype none

module salu_datapath (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire salu_pkg::ctl_t      ctl,
	input  wire salu_pkg::req_word_t req,
	output salu_pkg::rsp_word_t      rsp
);
	import salu_pkg::*;

	logic [2:0]  cmd_q;
	logic [31:0] a_q, b_q, hi_q, lo_q, res_q, mem_q;
	logic        neg_q, st_q;

	logic [32:0] x, y;
	logic        sub;
	logic [33:0] sum;
	logic        is_mul;
	logic [32:0] rem_sh;
	logic        ge;

	assign is_mul = (cmd_q == CMD_MUL);
	assign rem_sh = {hi_q, lo_q[31]};
	assign ge     = sum[33];

	always_comb begin
		x   = '0;
		y   = '0;
		sub = 1'b0;
		case (ctl.phase)
			ST_ARITH: begin
				x   = {a_q[31], a_q};
				y   = {b_q[31], b_q};
				sub = (cmd_q == CMD_SUB);
			end
			ST_ABS_A: begin
				y   = {1'b0, a_q};
				sub = 1'b1;
			end
			ST_ABS_B: begin
				y   = {1'b0, b_q};
				sub = 1'b1;
			end
			ST_ITER: begin
				x   = is_mul ? {1'b0, hi_q} : rem_sh;
				y   = {1'b0, b_q};
				sub = !is_mul;
			end
			ST_FIX: begin
				y   = {1'b0, lo_q};
				sub = neg_q;
			end
			default: begin
				x   = '0;
			end
		endcase
	end

	salu_addsub u_addsub (
		.x   (x),
		.y   (y),
		.sub (sub),
		.sum (sum)
	);

	// memory word is the only control-visible state here
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			mem_q <= '0;
		else if (ctl.load && req.command == CMD_STORE)
			mem_q <= req.operand_a;
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			cmd_q <= req.command;
			a_q   <= req.operand_a;
			b_q   <= req.operand_b;
			neg_q <= req.operand_a[31] ^ req.operand_b[31];
			// divide by zero flags at once; everything else starts clear
			st_q  <= (req.command == CMD_DIV) && (req.operand_b == '0);
			case (req.command)
				CMD_DIV: begin
					// divide by zero: saturate by dividend sign
					if (req.operand_a[31])
						res_q <= DIV0_NEG;
					else if (req.operand_a != '0)
						res_q <= DIV0_POS;
					else
						res_q <= DIV0_ZERO;
				end
				CMD_RECALL: res_q <= mem_q;
				default:    res_q <= '0;
			endcase
		end else begin
			case (ctl.phase)
				ST_ARITH: begin
					res_q <= sum[31:0];
					st_q  <= sum[32] ^ sum[31];
				end
				ST_ABS_A: begin
					if (a_q[31])
						a_q <= sum[31:0];
				end
				ST_ABS_B: begin
					if (b_q[31])
						b_q <= sum[31:0];
					hi_q <= '0;
					lo_q <= a_q;
				end
				ST_ITER: begin
					if (is_mul) begin
						if (lo_q[0]) begin
							hi_q <= sum[32:1];
							lo_q <= {sum[0], lo_q[31:1]};
						end else begin
							hi_q <= {1'b0, hi_q[31:1]};
							lo_q <= {hi_q[0], lo_q[31:1]};
						end
					end else begin
						hi_q <= ge ? sum[31:0] : rem_sh[31:0];
						lo_q <= {lo_q[30:0], ge};
					end
				end
				ST_FIX: begin
					res_q <= sum[31:0];
					if (is_mul)
						st_q <= (hi_q != '0) ||
							(lo_q[31] && !(neg_q && lo_q[30:0] == '0));
					else
						st_q <= lo_q[31] && !neg_q;
				end
				default: begin
					res_q <= res_q;
				end
			endcase
		end
	end

	assign rsp.value  = res_q;
	assign rsp.status = st_q;

endmodule

`default_nettype wire

@@ rtl/core/signed_alu_with_overflow_flag_top.sv @@
// ----------------------------------------------------------------------------
// signed_alu_with_overflow_flag_top - signed 32-bit ALU with memory word
// Add, subtract, multiply, divide, store and recall with overflow status.
// ----------------------------------------------------------------------------
// Usage:
//  - Request channel (req_valid/req_stall/req) takes one word: command and
//    two signed 32-bit operands. A word is taken when req_valid is high and
//    req_stall is low. req_stall stays high from acceptance until the
//    result word has been taken, so one command is in flight at a time.
//  - Response channel (rsp_valid/rsp_stall/rsp) gives one word per command:
//    value (low 32 bits of the exact result) and status (overflow or divide
//    by zero). rsp holds while rsp_stall is high.
//  - From acceptance, store, recall, divide by zero and unused codes go
//    straight to the response state; add and subtract take one pass of the
//    shared 33-bit adder; multiply and divide use the shared adder for one
//    pass each to take operand magnitudes, 32 shift-add or shift-subtract
//    passes and one pass to apply the result sign. A new word is taken the
//    cycle after the response goes.
//  - Reset clears the sequencer to idle and the memory word to zero.
// ----------------------------------------------------------------------------
`default_nettype none

module signed_alu_with_overflow_flag_top (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                req_valid,
	output logic                     req_stall,
	input  wire salu_pkg::req_word_t req,
	output logic                     rsp_valid,
	input  wire logic                rsp_stall,
	output salu_pkg::rsp_word_t      rsp
);
	import salu_pkg::*;

	ctl_t ctl;

	// sequencer: state, iteration count, handshake
	salu_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req       (req),
		.req_stall (req_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.ctl       (ctl)
	);

	// datapath: operands, partial product/remainder, result, memory word
	salu_datapath u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.req    (req),
		.rsp    (rsp)
	);

endmodule

`default_nettype wire

@@ tb/salu_result_checker.sv @@
// ----------------------------------------------------------------------------
// salu_result_checker - result predictor and comparator for the signed ALU
// Watches both channels, predicts each response word and compares in order.
// ----------------------------------------------------------------------------
`default_nettype none

module salu_result_checker (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                req_valid,
	input  wire logic                req_stall,
	input  wire salu_pkg::req_word_t req,
	input  wire logic                rsp_valid,
	input  wire logic                rsp_stall,
	input  wire salu_pkg::rsp_word_t rsp,
	output int                       fail_count,
	output int                       pending
);
	import salu_pkg::*;

	localparam longint S32_MAX = 64'sd2147483647;
	localparam longint S32_MIN = -64'sd2147483648;

	rsp_word_t   expected_rsp[$];
	logic [31:0] shadow_mem = '0;
	int          bad_words = 0;

	assign fail_count = bad_words;

	// Exact result at 64 bits, flag anything outside the signed 32-bit range.
	function automatic rsp_word_t alu_predict(input req_word_t w);
		longint    a;
		longint    b;
		longint    exact;
		rsp_word_t r;
		a     = w.operand_a;
		b     = w.operand_b;
		exact = 0;
		r     = '0;
		case (w.command)
			CMD_ADD, CMD_SUB, CMD_MUL: begin
				if (w.command == CMD_ADD)
					exact = a + b;
				else if (w.command == CMD_SUB)
					exact = a - b;
				else
					exact = a * b;
				r.value  = exact[31:0];
				r.status = (exact > S32_MAX) || (exact < S32_MIN);
			end
			CMD_DIV: begin
				if (b == 0) begin
					r.status = 1'b1;
					if (a > 0)
						r.value = DIV0_POS;
					else if (a < 0)
						r.value = DIV0_NEG;
					else
						r.value = DIV0_ZERO;
				end else begin
					// truncates toward zero; MIN / -1 lands on 2^31 and wraps
					exact    = a / b;
					r.value  = exact[31:0];
					r.status = (exact > S32_MAX) || (exact < S32_MIN);
				end
			end
			CMD_STORE: begin
				shadow_mem = w.operand_a;
			end
			CMD_RECALL: begin
				r.value = shadow_mem;
			end
			default: begin
			end
		endcase
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		rsp_word_t exp_w;
		if (!arst_n) begin
			expected_rsp.delete();
			shadow_mem = '0;
			pending <= 0;
		end else begin
			// response first: it always belongs to an earlier request
			if (rsp_valid && !rsp_stall) begin
				if (expected_rsp.size() == 0) begin
					bad_words++;
					if (bad_words <= 10)
						$display("%0t: unexpected response: value %h status %b",
							$realtime, rsp.value, rsp.status);
				end else begin
					exp_w = expected_rsp.pop_front();
					if (rsp.value !== exp_w.value || rsp.status !== exp_w.status) begin
						bad_words++;
						if (bad_words <= 10)
							$display("%0t: expected value %h status %b, got value %h status %b",
								$realtime, exp_w.value, exp_w.status,
								rsp.value, rsp.status);
					end
				end
			end
			if (req_valid && !req_stall)
				expected_rsp.push_back(alu_predict(req));
			pending <= expected_rsp.size();
		end
	end

endmodule

`default_nettype wire

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top - testbench for the signed ALU with overflow flag
// Directed corner words, then random words under random idling on both sides,
// a long response hold-off and a full drain; results checked in order.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
	import salu_pkg::*;

	localparam int N_RANDOM  = 1450;
	localparam int HOLD_LEN  = 400;   // long response hold-off, in cycles
	localparam int TAIL_CYCS = 40;    // idle tail after the final drain

	logic      clk       = 1'b0;
	logic      arst_n    = 1'b0;
	logic      req_valid = 1'b0;
	req_word_t req       = '0;
	logic      rsp_stall = 1'b0;
	logic      req_stall;
	logic      rsp_valid;
	rsp_word_t rsp;
	int        fail_count;
	int        pending;

	// quiet: no idling on either side; hold_tog: each flip asks for a hold-off
	logic quiet     = 1'b0;
	logic hold_tog  = 1'b0;
	logic hold_seen = 1'b0;
	int   hold_left = 0;

	always #10 clk = ~clk;

	signed_alu_with_overflow_flag_top u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	salu_result_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.req        (req),
		.rsp_valid  (rsp_valid),
		.rsp_stall  (rsp_stall),
		.rsp        (rsp),
		.fail_count (fail_count),
		.pending    (pending)
	);

	// Receiver: random stall about 31% of cycles, none while quiet.
	// A flip of hold_tog starts a hold-off counted down here.
	always @(posedge clk) begin
		if (hold_tog != hold_seen) begin
			hold_seen <= hold_tog;
			hold_left <= HOLD_LEN;
			rsp_stall <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			rsp_stall <= 1'b1;
		end else begin
			rsp_stall <= !quiet && ($urandom_range(0, 99) < 31);
		end
	end

	// Operand mix: full random, near zero, near the extremes, 16-bit, zero, powers of two.
	function automatic logic signed [31:0] rand_operand();
		logic [31:0] r;
		logic [31:0] v;
		r = $urandom;
		case ($urandom_range(0, 9))
			0, 1, 2, 3: v = r;
			4:          v = 32'($urandom_range(0, 32)) - 32'd16;
			5:          v = 32'h7FFF_FFFF - 32'($urandom_range(0, 15));
			6:          v = 32'h8000_0000 + 32'($urandom_range(0, 15));
			7:          v = {{16{r[15]}}, r[15:0]};
			8:          v = '0;
			default: begin
				v = 32'd1 << $urandom_range(0, 31);
				if (r[31])
					v = -v;
			end
		endcase
		return v;
	endfunction

	function automatic req_word_t make_random_cmd();
		req_word_t w;
		if ($urandom_range(0, 99) < 4)
			w.command = 3'($urandom_range(6, 7));   // unused codes
		else
			w.command = 3'($urandom_range(0, 5));
		w.operand_a = rand_operand();
		w.operand_b = rand_operand();
		if (w.command == CMD_DIV && $urandom_range(0, 9) == 0)
			w.operand_b = '0;
		return w;
	endfunction

	// Offer one word and hold it until taken. Idle gaps come before the offer,
	// so valid only ever drops between words.
	task automatic send_word(input req_word_t w);
		while (!quiet && $urandom_range(0, 99) < 31) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		if (!quiet && $urandom_range(0, 99) < 4) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(2, 40)) @(posedge clk);
		end
		req_valid <= 1'b1;
		req       <= w;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
	endtask

	task automatic send_cmd(input logic [2:0] cmd, input logic [31:0] a, input logic [31:0] b);
		req_word_t w;
		w.command   = cmd;
		w.operand_a = a;
		w.operand_b = b;
		send_word(w);
	endtask

	// Sender stops and waits for every outstanding response word.
	task automatic drain();
		req_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	initial begin
		int i;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// recall straight after reset reads the cleared memory word
		send_cmd(CMD_RECALL, 32'h1234_5678, 32'h9ABC_DEF0);
		// add/sub overflow at both ends and a clean MAX + MIN
		send_cmd(CMD_ADD, 32'h7FFF_FFFF, 32'h0000_0001);
		send_cmd(CMD_ADD, 32'h8000_0000, 32'hFFFF_FFFF);
		send_cmd(CMD_ADD, 32'h7FFF_FFFF, 32'h8000_0000);
		send_cmd(CMD_SUB, 32'h8000_0000, 32'h0000_0001);
		send_cmd(CMD_SUB, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
		send_cmd(CMD_SUB, 32'h0000_0000, 32'h8000_0000);
		// multiply: wide overflow, exactly 2^31 (over) and -2^31 (fits)
		send_cmd(CMD_MUL, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		send_cmd(CMD_MUL, 32'h8000_0000, 32'h8000_0000);
		send_cmd(CMD_MUL, 32'h8000_0000, 32'hFFFF_FFFF);
		send_cmd(CMD_MUL, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_cmd(CMD_MUL, 32'h0001_0000, 32'h0000_8000);
		send_cmd(CMD_MUL, 32'hFFFF_0000, 32'h0000_8000);
		// divide: truncation toward zero, MIN / -1, divide by zero per sign
		send_cmd(CMD_DIV, 32'h0000_0007, 32'hFFFF_FFFE);
		send_cmd(CMD_DIV, 32'hFFFF_FFF9, 32'h0000_0002);
		send_cmd(CMD_DIV, 32'h8000_0000, 32'hFFFF_FFFF);
		send_cmd(CMD_DIV, 32'h0000_0005, 32'h0000_0000);
		send_cmd(CMD_DIV, 32'hFFFF_FFFB, 32'h0000_0000);
		send_cmd(CMD_DIV, 32'h0000_0000, 32'h0000_0000);
		// memory store/recall; operand_b must be ignored
		send_cmd(CMD_STORE, 32'hDEAD_BEEF, 32'h5555_AAAA);
		send_cmd(CMD_RECALL, 32'h0000_0000, 32'hFFFF_FFFF);
		send_cmd(CMD_STORE, 32'h8000_0000, 32'h7FFF_FFFF);
		send_cmd(CMD_RECALL, 32'hFFFF_FFFF, 32'h0000_0000);
		// unused codes return zero and leave memory alone
		send_cmd(3'd6, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_cmd(3'd7, 32'h7FFF_FFFF, 32'h8000_0000);
		drain();

		for (i = 0; i < N_RANDOM; i++) begin
			if (i == 300)
				hold_tog <= ~hold_tog;   // receiver holds off, sender keeps offering
			if (i == 600)
				quiet <= 1'b1;
			if (i == 800)
				quiet <= 1'b0;
			if (i == 1000)
				drain();
			send_word(make_random_cmd());
		end

		drain();
		repeat (TAIL_CYCS) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("signed_alu_with_overflow_flag_top: match");
		else
			$display("signed_alu_with_overflow_flag_top: mismatch");
		$finish;
	end

	// Watchdog, far beyond the slowest legal run of about 1.5k words.
	initial begin
		#20_000_000;
		$display("signed_alu_with_overflow_flag_top: mismatch");
		$finish;
	end

endmodule

`default_nettype wire
